// ===== hw/rtl/pid_position_motor_drive_defines.svh =====
// Assertion macros for the position PID motor drive.
// Use one macro per assertion, on its own line, inside a module that has clk_i and rst_ni.
`ifndef PID_POSITION_MOTOR_DRIVE_DEFINES_SVH
`define PID_POSITION_MOTOR_DRIVE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only while out of reset.
`define PMD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, also during reset.
`define PMD_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define PMD_ASSERT(name, prop, msg)
`define PMD_ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ===== hw/rtl/pid_pmd_pkg.sv =====
package pid_pmd_pkg;

  // Field widths
  localparam int unsigned TGT_W  = 16;
  localparam int unsigned MEAS_W = 8;
  localparam int unsigned GAIN_W = 16;
  localparam int unsigned OUT_W  = 8;

  // Datapath widths: error -255..65535, integral saturates at 32 bits
  localparam int unsigned ERR_W   = 18;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned PE_W    = GAIN_W + ERR_W;   // gain * error or difference
  localparam int unsigned PI_W    = GAIN_W + SUM_W;   // gain * integral
  localparam int unsigned ACC_W   = PI_W + 2;         // sum of three products

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  // Largest value the compare fields can carry
  localparam int unsigned FIELD_MAX = (1 << OUT_W) - 1;

  // Parameter defaults
  localparam int unsigned GAIN_FRAC_BITS_DEF = 8;
  localparam int unsigned DUTY_MAX_DEF       = 255;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PROP  = 2'd0,
    CFG_INTEG = 2'd1,
    CFG_DERIV = 2'd2
  } cfg_idx_e;

  // Bridge drive direction codes
  typedef enum logic [1:0] {
    DIR_HOLD = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_REV  = 2'd2
  } drive_dir_e;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop;
    logic signed [GAIN_W-1:0] integ;
    logic signed [GAIN_W-1:0] deriv;
  } gains_t;

  // Error stage payload
  typedef struct packed {
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W-1:0] sum;
    logic signed [ERR_W-1:0] diff;
  } err_stage_t;

  // Product stage payload
  typedef struct packed {
    logic signed [PE_W-1:0] prop;
    logic signed [PI_W-1:0] integ;
    logic signed [PE_W-1:0] deriv;
  } prod_stage_t;

  // Result item
  typedef struct packed {
    logic [OUT_W-1:0] duty;
    drive_dir_e       dir;
    logic [OUT_W-1:0] rev_cmp;
    logic [OUT_W-1:0] fwd_cmp;
  } drive_out_t;

endpackage

// ===== hw/rtl/pid_pmd_err.sv =====
// Error, saturating integral and derivative; holds the loop state.
module pid_pmd_err (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           adv_i,
  input  logic                           in_vld_i,
  input  logic [pid_pmd_pkg::TGT_W-1:0]  target_i,
  input  logic [pid_pmd_pkg::MEAS_W-1:0] measured_i,
  output logic                           vld_o,
  output pid_pmd_pkg::err_stage_t        stage_o
);
  import pid_pmd_pkg::*;

  localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [ERR_W-1:0] prev_q;
  logic signed [ERR_W-1:0] err;
  logic signed [SUM_W:0]   sum_ext;
  logic                    vld_q;
  err_stage_t              stage_q;
  logic                    take;

  assign take = adv_i & in_vld_i;

  // Error and integral with saturation
  always_comb begin
    err     = signed'(ERR_W'(target_i)) - signed'(ERR_W'(measured_i));
    sum_ext = {sum_q[SUM_W-1], sum_q} + {{(SUM_W+1-ERR_W){err[ERR_W-1]}}, err};
    if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
      sum_d = sum_ext[SUM_W] ? SUM_LO : SUM_HI;
    end else begin
      sum_d = sum_ext[SUM_W-1:0];
    end
  end

  // Loop state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      prev_q <= '0;
      vld_q  <= 1'b0;
    end else begin
      if (adv_i) begin
        vld_q <= in_vld_i;
      end
      if (take) begin
        sum_q  <= sum_d;
        prev_q <= err;
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      stage_q.err  <= err;
      stage_q.sum  <= sum_d;
      stage_q.diff <= err - prev_q;
    end
  end

  assign vld_o   = vld_q;
  assign stage_o = stage_q;

endmodule

// ===== hw/rtl/pid_pmd_mult.sv =====
// Three gain multiplies, one register stage.
module pid_pmd_mult (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     vld_i,
  input  pid_pmd_pkg::err_stage_t  stage_i,
  input  pid_pmd_pkg::gains_t      gains_i,
  output logic                     vld_o,
  output pid_pmd_pkg::prod_stage_t prod_o
);
  import pid_pmd_pkg::*;

  logic        vld_q;
  prod_stage_t prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  // Exact signed products
  always_ff @(posedge clk_i) begin
    if (adv_i && vld_i) begin
      prod_q.prop  <= PE_W'(gains_i.prop)  * PE_W'(stage_i.err);
      prod_q.integ <= PI_W'(gains_i.integ) * PI_W'(stage_i.sum);
      prod_q.deriv <= PE_W'(gains_i.deriv) * PE_W'(stage_i.diff);
    end
  end

  assign vld_o  = vld_q;
  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/pid_pmd_drive.sv =====
`include "pid_position_motor_drive_defines.svh"

// Sum, fixed-point shift, clamp and compare hold; this is the result register.
module pid_pmd_drive #(
  parameter int unsigned GAIN_FRAC_BITS = pid_pmd_pkg::GAIN_FRAC_BITS_DEF,
  parameter int unsigned DUTY_MAX       = pid_pmd_pkg::DUTY_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     adv_i,
  input  logic                     vld_i,
  input  pid_pmd_pkg::prod_stage_t prod_i,
  output logic                     vld_o,
  output pid_pmd_pkg::drive_out_t  out_o
);
  import pid_pmd_pkg::*;

  // Clamp to the smaller of the duty limit and the field range
  localparam int unsigned DUTY_LIM = (DUTY_MAX < FIELD_MAX) ? DUTY_MAX : FIELD_MAX;
  localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(DUTY_LIM);
  localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;
  localparam logic [OUT_W-1:0]        LIM_OUT = OUT_W'(DUTY_LIM);

  logic signed [ACC_W-1:0] acc, res, res_neg;
  logic [OUT_W-1:0]        duty;
  drive_dir_e              dir;
  logic [OUT_W-1:0]        fwd_q, rev_q, duty_q;
  drive_dir_e              dir_q;
  logic                    vld_q;

  // Result, direction and clamped magnitude
  always_comb begin
    acc     = ACC_W'(prod_i.prop) + ACC_W'(prod_i.integ) + ACC_W'(prod_i.deriv);
    res     = acc >>> GAIN_FRAC_BITS;
    res_neg = -res;
    duty    = '0;
    dir     = DIR_HOLD;
    if (res > 0) begin
      dir  = DIR_FWD;
      duty = (res > LIM_POS) ? LIM_OUT : res[OUT_W-1:0];
    end else if (res < 0) begin
      dir  = DIR_REV;
      duty = (res < LIM_NEG) ? LIM_OUT : res_neg[OUT_W-1:0];
    end
  end

  // Held compares double as the output compare fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      fwd_q <= '0;
      rev_q <= '0;
    end else if (adv_i) begin
      vld_q <= vld_i;
      if (vld_i) begin
        unique case (dir)
          DIR_FWD: begin
            fwd_q <= duty;
            rev_q <= '0;
          end
          DIR_REV: begin
            fwd_q <= '0;
            rev_q <= duty;
          end
          default: begin
            fwd_q <= fwd_q;
            rev_q <= rev_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && vld_i) begin
      dir_q  <= dir;
      duty_q <= duty;
    end
  end

  assign vld_o         = vld_q;
  assign out_o.fwd_cmp = fwd_q;
  assign out_o.rev_cmp = rev_q;
  assign out_o.dir     = dir_q;
  assign out_o.duty    = duty_q;

  // Result consistency
  `PMD_ASSERT(a_fwd_cmp, (vld_q && dir_q == DIR_FWD) |-> (fwd_q == duty_q && rev_q == '0 && duty_q != '0), "forward result with bad compares")
  `PMD_ASSERT(a_rev_cmp, (vld_q && dir_q == DIR_REV) |-> (rev_q == duty_q && fwd_q == '0 && duty_q != '0), "reverse result with bad compares")
  `PMD_ASSERT(a_hold_cmp, (vld_q && dir_q == DIR_HOLD) |-> (duty_q == '0), "zero result with nonzero duty")
  `PMD_ASSERT(a_duty_lim, vld_q |-> (duty_q <= LIM_OUT && fwd_q <= LIM_OUT && rev_q <= LIM_OUT), "duty above limit")
  `PMD_ASSERT(a_one_side, (fwd_q == '0) || (rev_q == '0), "both bridge channels driven")

endmodule

// ===== hw/rtl/pid_position_motor_drive.sv =====
// Position PID loop with H-bridge PWM compare outputs.
// Stages from input transfer to result: error stage, multiply stage, result.
// Throughput: one item per cycle; the three-stage pipeline stalls as a whole on output backpressure.
// Reset (rst_ni low, asynchronous): gains, integral, previous error and held compares clear to zero.
module pid_position_motor_drive #(
  parameter int unsigned GAIN_FRAC_BITS = pid_pmd_pkg::GAIN_FRAC_BITS_DEF,
  parameter int unsigned DUTY_MAX       = pid_pmd_pkg::DUTY_MAX_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_idx_i,
  input  logic [pid_pmd_pkg::GAIN_W-1:0]     cfg_data_i,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [15:0] target_position, [23:16] measured_position
  input  logic [pid_pmd_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [7:0] forward_compare, [15:8] reverse_compare, [17:16] drive_direction,
  // [25:18] duty_magnitude, [31:26] zero
  output logic [pid_pmd_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import pid_pmd_pkg::*;

  gains_t      gains_q;
  logic        adv;
  logic        a_vld, b_vld, c_vld;
  err_stage_t  a_stage;
  prod_stage_t b_prod;
  drive_out_t  c_out;

  // Pipeline moves when the result register is free or being taken
  assign adv           = ~c_vld | m_axis_tready;
  assign s_axis_tready = adv;

  // Gain registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PROP:  gains_q.prop  <= cfg_data_i;
        CFG_INTEG: gains_q.integ <= cfg_data_i;
        CFG_DERIV: gains_q.deriv <= cfg_data_i;
        default:   gains_q       <= gains_q;
      endcase
    end
  end

  pid_pmd_err u_err (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .in_vld_i   (s_axis_tvalid),
    .target_i   (s_axis_tdata[TGT_W-1:0]),
    .measured_i (s_axis_tdata[TGT_W+MEAS_W-1:TGT_W]),
    .vld_o      (a_vld),
    .stage_o    (a_stage)
  );

  pid_pmd_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (a_vld),
    .stage_i (a_stage),
    .gains_i (gains_q),
    .vld_o   (b_vld),
    .prod_o  (b_prod)
  );

  pid_pmd_drive #(
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .DUTY_MAX       (DUTY_MAX)
  ) u_drive (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (b_vld),
    .prod_i (b_prod),
    .vld_o  (c_vld),
    .out_o  (c_out)
  );

  assign m_axis_tvalid = c_vld;
  assign m_axis_tdata  = OUT_DATA_W'(c_out);

endmodule
